### rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
// Field widths, result codes, controller steps and the control/status structs.
// No dependencies.
package lobm_pkg;

	localparam int ID_W    = 12;
	localparam int PRICE_W = 10;
	localparam int QTY_W   = 32;
	localparam int KIND_W  = 3;
	localparam int LVLO_W  = 10;
	localparam int TOTAL_W = 13;
	localparam int CFG_W   = 11;
	localparam int FILL_W  = 6;
	localparam int BUF_D   = 64;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_CANCEL = 1'b1;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TRADE          = 3'd0,
		KIND_ADD_DONE       = 3'd1,
		KIND_CANCEL_OK      = 3'd2,
		KIND_CANCEL_UNKNOWN = 3'd3,
		KIND_LEVEL_FULL     = 3'd4,
		KIND_FILLS_TRUNC    = 3'd5
	} kind_t;

	typedef enum logic [15:0] {
		ST_INIT     = 16'h0001,
		ST_IDLE     = 16'h0002,
		ST_LOC_RD   = 16'h0004,
		ST_LOC_CHK  = 16'h0008,
		ST_RM_UPD   = 16'h0010,
		ST_S_RD     = 16'h0020,
		ST_S_CHK    = 16'h0040,
		ST_M_BEST   = 16'h0080,
		ST_M_LP     = 16'h0100,
		ST_M_INNER  = 16'h0200,
		ST_M_ENT    = 16'h0400,
		ST_M_EMPTY  = 16'h0800,
		ST_REST     = 16'h1000,
		ST_REST_LP  = 16'h2000,
		ST_E_RD     = 16'h4000,
		ST_E_WR     = 16'h8000
	} step_t;

	typedef struct packed {
		step_t step;
		logic  take;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic loc_valid;
		logic is_cancel;
		logic need_search;
		logic srch_end;
		logic match_go;
		logic inner_go;
		logic ct_zero;
		logic trunc_hit;
		logic rest_go;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

### rtl/lobm_if.sv
// Handshake channels of the order book: request, result and configuration.
// Depends on lobm_pkg for field widths.
interface lobm_req_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [lobm_pkg::ID_W-1:0]     order_id;
	logic                          is_buy;
	logic                          is_limit;
	logic [lobm_pkg::PRICE_W-1:0]  price_ticks;
	logic [lobm_pkg::QTY_W-1:0]    quantity;
	modport source (output valid, op, order_id, is_buy, is_limit, price_ticks, quantity,
		input ready);
	modport sink (input valid, op, order_id, is_buy, is_limit, price_ticks, quantity,
		output ready);
endinterface

interface lobm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lobm_pkg::KIND_W-1:0]   kind;
	logic [lobm_pkg::ID_W-1:0]     buyer_id;
	logic [lobm_pkg::ID_W-1:0]     seller_id;
	logic [lobm_pkg::LVLO_W-1:0]   trade_level;
	logic [lobm_pkg::QTY_W-1:0]    trade_quantity;
	logic                          bid_valid;
	logic [lobm_pkg::LVLO_W-1:0]   best_bid_level;
	logic                          ask_valid;
	logic [lobm_pkg::LVLO_W-1:0]   best_ask_level;
	logic [lobm_pkg::TOTAL_W-1:0]  resting_total;
	logic                          last;
	modport source (output valid, kind, buyer_id, seller_id, trade_level, trade_quantity,
		bid_valid, best_bid_level, ask_valid, best_ask_level, resting_total, last,
		input ready);
	modport sink (input valid, kind, buyer_id, seller_id, trade_level, trade_quantity,
		bid_valid, best_bid_level, ask_valid, best_ask_level, resting_total, last,
		output ready);
endinterface

interface lobm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lobm_pkg::CFG_W-1:0]  levels_in_use;
	modport source (output valid, levels_in_use, input ready);
	modport sink (input valid, levels_in_use, output ready);
endinterface

### rtl/limit_order_book_matcher.sv
// Limit order book: a request looks up its order's location, removes a found entry,
// searches the bitmaps 32 levels per word for a new best level, visits resting
// entries, rests a limit remainder and emits its result words; each step reads or
// writes the book memories. One request is handled at a time; the next is taken
// once its last word is loaded. After reset a clearing pass empties the level,
// location and bitmap tables; requests wait, config is taken.
module limit_order_book_matcher #(
	parameter int NUM_LEVELS  = 1024,
	parameter int LEVEL_DEPTH = 128,
	parameter int MAX_ORDERS  = 4096,
	parameter int MAX_FILLS   = 63
) (
	input logic        clk,
	input logic        arst_n,
	lobm_req_if.sink   req,
	lobm_rsp_if.source rsp,
	lobm_cfg_if.sink   cfg
);

	lobm_pkg::cmd_t cmd;
	lobm_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	lobm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lobm_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.MAX_ORDERS  (MAX_ORDERS),
		.MAX_FILLS   (MAX_FILLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_op        (req.op),
		.req_id        (req.order_id),
		.req_buy       (req.is_buy),
		.req_lim       (req.is_limit),
		.req_price     (req.price_ticks),
		.req_qty       (req.quantity),
		.cfg_fire      (cfg.valid),
		.cfg_data      (cfg.levels_in_use),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.rsp_kind      (rsp.kind),
		.rsp_buyer     (rsp.buyer_id),
		.rsp_seller    (rsp.seller_id),
		.rsp_level     (rsp.trade_level),
		.rsp_qty       (rsp.trade_quantity),
		.rsp_bid_valid (rsp.bid_valid),
		.rsp_bid_level (rsp.best_bid_level),
		.rsp_ask_valid (rsp.ask_valid),
		.rsp_ask_level (rsp.best_ask_level),
		.rsp_total     (rsp.resting_total),
		.rsp_last      (rsp.last)
	);

endmodule

### rtl/lobm_ctrl.sv
// Sequencer of the order book: one-hot state machine that steps the datapath.
// Depends on lobm_pkg (step_t, cmd_t, sts_t).
module lobm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lobm_pkg::sts_t   sts,
	output lobm_pkg::cmd_t   cmd
);

	lobm_pkg::step_t state_q, state_d;

	assign req_ready = (state_q == lobm_pkg::ST_IDLE);
	assign cmd.step  = state_q;
	assign cmd.take  = req_valid && (state_q == lobm_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lobm_pkg::ST_INIT: begin
				if (sts.init_done) state_d = lobm_pkg::ST_IDLE;
			end
			lobm_pkg::ST_IDLE: begin
				if (req_valid) state_d = lobm_pkg::ST_LOC_RD;
			end
			lobm_pkg::ST_LOC_RD: state_d = lobm_pkg::ST_LOC_CHK;
			lobm_pkg::ST_LOC_CHK: begin
				if (sts.loc_valid) state_d = lobm_pkg::ST_RM_UPD;
				else if (sts.is_cancel) state_d = lobm_pkg::ST_E_RD;
				else state_d = lobm_pkg::ST_M_BEST;
			end
			lobm_pkg::ST_RM_UPD: begin
				if (sts.need_search) state_d = lobm_pkg::ST_S_RD;
				else if (sts.is_cancel) state_d = lobm_pkg::ST_E_RD;
				else state_d = lobm_pkg::ST_M_BEST;
			end
			lobm_pkg::ST_S_RD: state_d = lobm_pkg::ST_S_CHK;
			lobm_pkg::ST_S_CHK: begin
				if (!sts.srch_end) state_d = lobm_pkg::ST_S_RD;
				else if (sts.is_cancel) state_d = lobm_pkg::ST_E_RD;
				else state_d = lobm_pkg::ST_M_BEST;
			end
			lobm_pkg::ST_M_BEST: begin
				if (sts.match_go) state_d = lobm_pkg::ST_M_LP;
				else state_d = lobm_pkg::ST_REST;
			end
			lobm_pkg::ST_M_LP: state_d = lobm_pkg::ST_M_INNER;
			lobm_pkg::ST_M_INNER: begin
				if (sts.inner_go) state_d = lobm_pkg::ST_M_ENT;
				else if (sts.ct_zero) state_d = lobm_pkg::ST_M_EMPTY;
				else state_d = lobm_pkg::ST_REST;
			end
			lobm_pkg::ST_M_ENT: begin
				if (sts.trunc_hit) state_d = lobm_pkg::ST_E_RD;
				else state_d = lobm_pkg::ST_M_INNER;
			end
			lobm_pkg::ST_M_EMPTY: state_d = lobm_pkg::ST_S_RD;
			lobm_pkg::ST_REST: begin
				if (sts.rest_go) state_d = lobm_pkg::ST_REST_LP;
				else state_d = lobm_pkg::ST_E_RD;
			end
			lobm_pkg::ST_REST_LP: state_d = lobm_pkg::ST_E_RD;
			lobm_pkg::ST_E_RD: state_d = lobm_pkg::ST_E_WR;
			lobm_pkg::ST_E_WR: begin
				if (sts.out_free) begin
					if (sts.emit_last) state_d = lobm_pkg::ST_IDLE;
					else state_d = lobm_pkg::ST_E_RD;
				end
			end
			default: state_d = lobm_pkg::ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lobm_pkg::ST_INIT;
		else state_q <= state_d;
	end

endmodule

### rtl/lobm_dp.sv
// Datapath of the order book: location table, level pointers, resting entries,
// occupancy bitmaps, best-level registers, fill buffer and result register.
// Depends on lobm_pkg; stepped by lobm_ctrl.
module lobm_dp #(
	parameter int NUM_LEVELS  = 1024,
	parameter int LEVEL_DEPTH = 128,
	parameter int MAX_ORDERS  = 4096,
	parameter int MAX_FILLS   = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lobm_pkg::cmd_t                cmd,
	output lobm_pkg::sts_t                sts,
	input  logic                          req_op,
	input  logic [lobm_pkg::ID_W-1:0]     req_id,
	input  logic                          req_buy,
	input  logic                          req_lim,
	input  logic [lobm_pkg::PRICE_W-1:0]  req_price,
	input  logic [lobm_pkg::QTY_W-1:0]    req_qty,
	input  logic                          cfg_fire,
	input  logic [lobm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [lobm_pkg::KIND_W-1:0]   rsp_kind,
	output logic [lobm_pkg::ID_W-1:0]     rsp_buyer,
	output logic [lobm_pkg::ID_W-1:0]     rsp_seller,
	output logic [lobm_pkg::LVLO_W-1:0]   rsp_level,
	output logic [lobm_pkg::QTY_W-1:0]    rsp_qty,
	output logic                          rsp_bid_valid,
	output logic [lobm_pkg::LVLO_W-1:0]   rsp_bid_level,
	output logic                          rsp_ask_valid,
	output logic [lobm_pkg::LVLO_W-1:0]   rsp_ask_level,
	output logic [lobm_pkg::TOTAL_W-1:0]  rsp_total,
	output logic                          rsp_last
);

	// sizes are powers of two: addresses are plain concatenations
	localparam int LW    = $clog2(NUM_LEVELS);
	localparam int PW    = $clog2(LEVEL_DEPTH);
	localparam int HW    = PW + 1;
	localparam int OW    = $clog2(MAX_ORDERS);
	localparam int RCW   = $clog2(MAX_ORDERS + 1);
	localparam int WPS   = NUM_LEVELS / 32;
	localparam int WW    = LW - 5;
	localparam int BMD   = 2 * WPS;
	localparam int BW    = WW + 1;
	localparam int LPD   = 2 * NUM_LEVELS;
	localparam int LPA   = LW + 1;
	localparam int ED    = 2 * NUM_LEVELS * LEVEL_DEPTH;
	localparam int EA    = LW + 1 + PW;
	localparam int CLR_N = (LPD > MAX_ORDERS) ? LPD : MAX_ORDERS;
	localparam int CLRW  = $clog2(CLR_N);
	localparam int LOCW  = 2 + LW + PW;
	localparam int LPW   = 3 * HW;
	localparam int ENTW  = lobm_pkg::ID_W + lobm_pkg::QTY_W + 1;
	localparam int BUFW  = 2 * lobm_pkg::ID_W + lobm_pkg::LVLO_W + lobm_pkg::QTY_W;
	localparam int FW    = lobm_pkg::FILL_W;

	function automatic logic [4:0] hi_bit(input logic [31:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) if (w[i]) r = 5'(i);
		return r;
	endfunction

	function automatic logic [4:0] lo_bit(input logic [31:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) if (w[i]) r = 5'(i);
		return r;
	endfunction

	// memories
	logic [LPW-1:0]  lp_mem  [LPD];
	logic [LOCW-1:0] loc_mem [MAX_ORDERS];
	logic [ENTW-1:0] ent_mem [ED];
	logic [31:0]     bm_mem  [BMD];
	logic [BUFW-1:0] buf_mem [lobm_pkg::BUF_D];

	logic            lp_we, lp_re;
	logic [LPA-1:0]  lp_wa, lp_ra;
	logic [LPW-1:0]  lp_wd, lp_rd;
	logic            loc_we, loc_re;
	logic [OW-1:0]   loc_wa, loc_ra;
	logic [LOCW-1:0] loc_wd, loc_rd;
	logic            ent_we, ent_re;
	logic [EA-1:0]   ent_wa, ent_ra;
	logic [ENTW-1:0] ent_wd, ent_rd;
	logic            bm_we, bm_re;
	logic [BW-1:0]   bm_wa, bm_ra;
	logic [31:0]     bm_wd, bm_rd;
	logic            buf_we;
	logic [FW-1:0]   buf_wa;
	logic [BUFW-1:0] buf_wd, buf_rd;

	// request and working registers
	logic                          op_q, buy_q, lim_q;
	logic [lobm_pkg::ID_W-1:0]     id_q;
	logic [lobm_pkg::PRICE_W-1:0]  price_q;
	logic [lobm_pkg::QTY_W-1:0]    rem_q;
	logic [lobm_pkg::KIND_W-1:0]   kind_q;
	logic [FW-1:0]                 n_q, k_q;
	logic [LPA-1:0]                lp_a_q;
	logic [EA-1:0]                 ent_a_q;
	logic [BW-1:0]                 bm_a_q;
	logic [LW-1:0]                 mlvl_q, rlvl_q;
	logic [HW-1:0]                 hd_q, tl_q, ct_q;
	logic                          srch_side_q;
	logic [WW-1:0]                 srch_w_q;
	logic                          bid_ok_q, ask_ok_q;
	logic [LW-1:0]                 bid_idx_q, ask_idx_q;
	logic [RCW-1:0]                rcnt_q;
	logic [lobm_pkg::CFG_W-1:0]    lvl_in_q;
	logic [CLRW-1:0]               clr_q;
	logic                          rsp_valid_q;

	// decoded read data
	logic [31:0]                   id_ext, eid_ext;
	logic [OW-1:0]                 slot, eslot;
	logic                          loc_v, loc_side;
	logic [LW-1:0]                 loc_lvl;
	logic [PW-1:0]                 loc_pos;
	logic [HW-1:0]                 rd_hd, rd_tl, rd_ct, rm_ct;
	logic [lobm_pkg::ID_W-1:0]     e_id;
	logic [lobm_pkg::QTY_W-1:0]    e_rem, fill, new_erem;
	logic                          e_act, rm_empty, fill_go, lp_full;
	logic [LW-1:0]                 m_lvl_c, r_lvl_c;
	logic [31:0]                   lim_c, rl_c, mlvl_ext, bid_ext, ask_ext, rcnt_ext;
	logic                          found;
	logic [lobm_pkg::ID_W-1:0]     buyer_c, seller_c;

	assign id_ext   = 32'(id_q);
	assign slot     = id_ext[OW-1:0];
	assign loc_v    = loc_rd[LOCW-1];
	assign loc_side = loc_rd[LOCW-2];
	assign loc_lvl  = loc_rd[PW +: LW];
	assign loc_pos  = loc_rd[PW-1:0];
	assign rd_hd    = lp_rd[2*HW +: HW];
	assign rd_tl    = lp_rd[HW +: HW];
	assign rd_ct    = lp_rd[0 +: HW];
	assign e_id     = ent_rd[ENTW-1 -: lobm_pkg::ID_W];
	assign e_rem    = ent_rd[1 +: lobm_pkg::QTY_W];
	assign e_act    = ent_rd[0];
	assign eid_ext  = 32'(e_id);
	assign eslot    = eid_ext[OW-1:0];
	assign rm_ct    = (e_act && rd_ct != '0) ? rd_ct - HW'(1) : rd_ct;
	assign rm_empty = (rm_ct == '0);
	assign fill     = (rem_q < e_rem) ? rem_q : e_rem;
	assign new_erem = e_rem - fill;
	assign fill_go  = e_act && !sts.trunc_hit;
	assign lp_full  = 32'(rd_tl) >= LEVEL_DEPTH;
	assign m_lvl_c  = buy_q ? ask_idx_q : bid_idx_q;
	assign mlvl_ext = 32'(mlvl_q);
	assign found    = (bm_rd != '0);
	assign buyer_c  = buy_q ? id_q : e_id;
	assign seller_c = buy_q ? e_id : id_q;

	// resting level: price clamped to the levels in use
	always_comb begin
		lim_c = 32'(lvl_in_q);
		if (lim_c < 32'd1) lim_c = 32'd1;
		if (lim_c > 32'(NUM_LEVELS)) lim_c = 32'(NUM_LEVELS);
		rl_c = (32'(price_q) < lim_c - 32'd1) ? 32'(price_q) : lim_c - 32'd1;
		r_lvl_c = rl_c[LW-1:0];
	end

	// status to the sequencer
	always_comb begin
		sts.init_done   = (clr_q == CLRW'(CLR_N - 1));
		sts.loc_valid   = loc_v;
		sts.is_cancel   = (op_q == lobm_pkg::OP_CANCEL);
		sts.need_search = rm_empty && ((loc_side == lobm_pkg::SIDE_ASK) ?
			(ask_ok_q && ask_idx_q == loc_lvl) : (bid_ok_q && bid_idx_q == loc_lvl));
		sts.srch_end    = found || ((srch_side_q == lobm_pkg::SIDE_ASK) ?
			(srch_w_q == WW'(WPS - 1)) : (srch_w_q == '0));
		if (buy_q)
			sts.match_go = (rem_q != '0) && ask_ok_q &&
				!(lim_q && 32'(price_q) < 32'(ask_idx_q));
		else
			sts.match_go = (rem_q != '0) && bid_ok_q &&
				!(lim_q && 32'(price_q) > 32'(bid_idx_q));
		sts.inner_go    = (hd_q < tl_q) && (32'(hd_q) < LEVEL_DEPTH) && (rem_q != '0);
		sts.ct_zero     = (ct_q == '0);
		sts.trunc_hit   = e_act && (32'(n_q) >= MAX_FILLS);
		sts.rest_go     = (rem_q != '0) && lim_q;
		sts.out_free    = !rsp_valid_q || rsp_ready;
		sts.emit_last   = (k_q == n_q);
	end

	// memory port control
	always_comb begin
		lp_we = 1'b0; lp_wa = lp_a_q; lp_wd = '0; lp_re = 1'b0; lp_ra = '0;
		loc_we = 1'b0; loc_wa = slot; loc_wd = '0; loc_re = 1'b0; loc_ra = slot;
		ent_we = 1'b0; ent_wa = ent_a_q; ent_wd = '0; ent_re = 1'b0; ent_ra = '0;
		bm_we = 1'b0; bm_wa = bm_a_q; bm_wd = '0; bm_re = 1'b0; bm_ra = '0;
		buf_we = 1'b0; buf_wa = n_q; buf_wd = '0;
		case (cmd.step)
			lobm_pkg::ST_INIT: begin
				lp_we  = 32'(clr_q) < LPD;
				lp_wa  = clr_q[LPA-1:0];
				loc_we = 32'(clr_q) < MAX_ORDERS;
				loc_wa = clr_q[OW-1:0];
				bm_we  = 32'(clr_q) < BMD;
				bm_wa  = clr_q[BW-1:0];
			end
			lobm_pkg::ST_LOC_RD: loc_re = 1'b1;
			lobm_pkg::ST_LOC_CHK: begin
				lp_re  = 1'b1;
				lp_ra  = {loc_side, loc_lvl};
				ent_re = 1'b1;
				ent_ra = {loc_side, loc_lvl, loc_pos};
				bm_re  = 1'b1;
				bm_ra  = {loc_side, loc_lvl[LW-1:5]};
			end
			lobm_pkg::ST_RM_UPD: begin
				lp_we  = 1'b1;
				lp_wd  = rm_empty ? '0 : {rd_hd, rd_tl, rm_ct};
				ent_we = 1'b1;
				ent_wd = {e_id, e_rem, 1'b0};
				loc_we = 1'b1;
				bm_we  = rm_empty;
				bm_wd  = bm_rd & ~(32'd1 << loc_lvl[4:0]);
			end
			lobm_pkg::ST_S_RD: begin
				bm_re = 1'b1;
				bm_ra = {srch_side_q, srch_w_q};
			end
			lobm_pkg::ST_M_BEST: begin
				lp_re = 1'b1;
				lp_ra = {buy_q, m_lvl_c};
			end
			lobm_pkg::ST_M_INNER: begin
				ent_re = 1'b1;
				ent_ra = {buy_q, mlvl_q, hd_q[PW-1:0]};
				bm_re  = 1'b1;
				bm_ra  = {buy_q, mlvl_q[LW-1:5]};
				lp_we  = !sts.inner_go;
				lp_wd  = sts.ct_zero ? '0 : {hd_q, tl_q, ct_q};
			end
			lobm_pkg::ST_M_ENT: begin
				lp_we  = sts.trunc_hit;
				lp_wd  = {hd_q, tl_q, ct_q};
				ent_we = fill_go;
				ent_wd = {e_id, new_erem, new_erem != '0};
				loc_we = fill_go && (new_erem == '0);
				loc_wa = eslot;
				buf_we = fill_go;
				buf_wd = {buyer_c, seller_c, mlvl_ext[lobm_pkg::LVLO_W-1:0], fill};
			end
			lobm_pkg::ST_M_EMPTY: begin
				bm_we = 1'b1;
				bm_wd = bm_rd & ~(32'd1 << mlvl_q[4:0]);
			end
			lobm_pkg::ST_REST: begin
				lp_re = 1'b1;
				lp_ra = {~buy_q, r_lvl_c};
				bm_re = 1'b1;
				bm_ra = {~buy_q, r_lvl_c[LW-1:5]};
			end
			lobm_pkg::ST_REST_LP: begin
				lp_we  = !lp_full;
				lp_wd  = {rd_hd, rd_tl + HW'(1), rd_ct + HW'(1)};
				ent_we = !lp_full;
				ent_wa = {~buy_q, rlvl_q, rd_tl[PW-1:0]};
				ent_wd = {id_q, rem_q, 1'b1};
				loc_we = !lp_full;
				loc_wd = {1'b1, ~buy_q, rlvl_q, rd_tl[PW-1:0]};
				bm_we  = !lp_full;
				bm_wd  = bm_rd | (32'd1 << rlvl_q[4:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lp_we) lp_mem[lp_wa] <= lp_wd;
		if (lp_re) lp_rd <= lp_mem[lp_ra];
	end

	always_ff @(posedge clk) begin
		if (loc_we) loc_mem[loc_wa] <= loc_wd;
		if (loc_re) loc_rd <= loc_mem[loc_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (ent_re) ent_rd <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_wa] <= bm_wd;
		if (bm_re) bm_rd <= bm_mem[bm_ra];
	end

	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[buf_wa] <= buf_wd;
		if (cmd.step == lobm_pkg::ST_E_RD) buf_rd <= buf_mem[k_q];
	end

	// control state: book summary, counters, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_ok_q    <= 1'b0;
			ask_ok_q    <= 1'b0;
			bid_idx_q   <= '0;
			ask_idx_q   <= '0;
			rcnt_q      <= '0;
			lvl_in_q    <= lobm_pkg::CFG_W'(1024);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			n_q         <= '0;
			kind_q      <= lobm_pkg::KIND_ADD_DONE;
		end else begin
			if (cfg_fire) lvl_in_q <= cfg_data;
			if (cmd.take) begin
				n_q    <= '0;
				kind_q <= (req_op == lobm_pkg::OP_CANCEL) ?
					lobm_pkg::KIND_CANCEL_OK : lobm_pkg::KIND_ADD_DONE;
			end
			case (cmd.step)
				lobm_pkg::ST_INIT: clr_q <= clr_q + CLRW'(1);
				lobm_pkg::ST_LOC_CHK: begin
					if (!loc_v && op_q == lobm_pkg::OP_CANCEL)
						kind_q <= lobm_pkg::KIND_CANCEL_UNKNOWN;
				end
				lobm_pkg::ST_RM_UPD: begin
					if (rcnt_q != '0) rcnt_q <= rcnt_q - RCW'(1);
				end
				lobm_pkg::ST_S_CHK: begin
					if (srch_side_q == lobm_pkg::SIDE_ASK) begin
						if (found) begin
							ask_ok_q  <= 1'b1;
							ask_idx_q <= {srch_w_q, lo_bit(bm_rd)};
						end else if (sts.srch_end) begin
							ask_ok_q  <= 1'b0;
							ask_idx_q <= '0;
						end
					end else begin
						if (found) begin
							bid_ok_q  <= 1'b1;
							bid_idx_q <= {srch_w_q, hi_bit(bm_rd)};
						end else if (sts.srch_end) begin
							bid_ok_q  <= 1'b0;
							bid_idx_q <= '0;
						end
					end
				end
				lobm_pkg::ST_M_ENT: begin
					if (sts.trunc_hit) kind_q <= lobm_pkg::KIND_FILLS_TRUNC;
					if (fill_go) begin
						n_q <= n_q + FW'(1);
						if (new_erem == '0 && rcnt_q != '0) rcnt_q <= rcnt_q - RCW'(1);
					end
				end
				lobm_pkg::ST_REST_LP: begin
					if (lp_full) begin
						kind_q <= lobm_pkg::KIND_LEVEL_FULL;
					end else begin
						rcnt_q <= rcnt_q + RCW'(1);
						if (buy_q) begin
							if (!bid_ok_q || rlvl_q > bid_idx_q) begin
								bid_ok_q  <= 1'b1;
								bid_idx_q <= rlvl_q;
							end
						end else begin
							if (!ask_ok_q || rlvl_q < ask_idx_q) begin
								ask_ok_q  <= 1'b1;
								ask_idx_q <= rlvl_q;
							end
						end
					end
				end
				default: begin
				end
			endcase
			if (cmd.step == lobm_pkg::ST_E_WR && sts.out_free) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= req_op;
			id_q    <= req_id;
			buy_q   <= req_buy;
			lim_q   <= req_lim;
			price_q <= req_price;
			rem_q   <= req_qty;
			k_q     <= '0;
		end
		if (lp_re) lp_a_q <= lp_ra;
		if (ent_re) ent_a_q <= ent_ra;
		if (bm_re) bm_a_q <= bm_ra;
		case (cmd.step)
			lobm_pkg::ST_RM_UPD: begin
				srch_side_q <= loc_side;
				srch_w_q    <= loc_lvl[LW-1:5];
			end
			lobm_pkg::ST_S_CHK: begin
				if (srch_side_q == lobm_pkg::SIDE_ASK) srch_w_q <= srch_w_q + WW'(1);
				else srch_w_q <= srch_w_q - WW'(1);
			end
			lobm_pkg::ST_M_BEST: mlvl_q <= m_lvl_c;
			lobm_pkg::ST_M_LP: begin
				hd_q <= rd_hd;
				tl_q <= rd_tl;
				ct_q <= rd_ct;
			end
			lobm_pkg::ST_M_ENT: begin
				if (!e_act) begin
					hd_q <= hd_q + HW'(1);
				end else if (fill_go) begin
					rem_q <= rem_q - fill;
					if (new_erem == '0) begin
						hd_q <= hd_q + HW'(1);
						if (ct_q != '0) ct_q <= ct_q - HW'(1);
					end
				end
			end
			lobm_pkg::ST_M_EMPTY: begin
				srch_side_q <= buy_q;
				srch_w_q    <= mlvl_q[LW-1:5];
			end
			lobm_pkg::ST_REST: rlvl_q <= r_lvl_c;
			lobm_pkg::ST_E_WR: begin
				if (sts.out_free) k_q <= k_q + FW'(1);
			end
			default: begin
			end
		endcase
	end

	// result register
	assign bid_ext  = 32'(bid_idx_q);
	assign ask_ext  = 32'(ask_idx_q);
	assign rcnt_ext = 32'(rcnt_q);

	always_ff @(posedge clk) begin
		if (cmd.step == lobm_pkg::ST_E_WR && sts.out_free) begin
			if (sts.emit_last) begin
				rsp_kind   <= kind_q;
				rsp_buyer  <= '0;
				rsp_seller <= '0;
				rsp_level  <= '0;
				rsp_qty    <= '0;
			end else begin
				rsp_kind   <= lobm_pkg::KIND_TRADE;
				{rsp_buyer, rsp_seller, rsp_level, rsp_qty} <= buf_rd;
			end
			rsp_bid_valid <= bid_ok_q;
			rsp_bid_level <= bid_ext[lobm_pkg::LVLO_W-1:0];
			rsp_ask_valid <= ask_ok_q;
			rsp_ask_level <= ask_ext[lobm_pkg::LVLO_W-1:0];
			rsp_total     <= rcnt_ext[lobm_pkg::TOTAL_W-1:0];
			rsp_last      <= sts.emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= MAX_FILLS)
		else $error("fill count past limit");

	a_trunc_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == lobm_pkg::ST_M_ENT && sts.trunc_hit) |=>
		(kind_q == lobm_pkg::KIND_FILLS_TRUNC))
		else $error("truncation not recorded");

	a_empty_bid: assert property (@(posedge clk) disable iff (!arst_n)
		!bid_ok_q |-> (bid_idx_q == '0 && !(ask_ok_q == 1'b0 && ask_idx_q != '0)))
		else $error("empty book side holds a level");

	a_last_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == lobm_pkg::ST_E_WR && sts.out_free && sts.emit_last) |=>
		(rsp_valid_q && rsp_last))
		else $error("final word not loaded");

	a_rest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rcnt_q) <= MAX_ORDERS)
		else $error("resting count past order capacity");

endmodule
